// ===== rtl/sha256_hash_assert.svh =====
// Assertion macros shared by the hash block
`ifndef SHA256_HASH_ASSERT_SVH
`define SHA256_HASH_ASSERT_SVH

// Condition in this cycle implies a condition in the same cycle
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Condition in this cycle implies a condition in the next cycle
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps

package sha256_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] digest_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD
   } state_type;

   // Source of a word shifted into the schedule window
   typedef enum logic [2:0] {
      PUSH_DATA,
      PUSH_TAIL,
      PUSH_MARKER,
      PUSH_ZERO,
      PUSH_LEN_HI,
      PUSH_LEN_LO
   } push_sel_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic         push;
      push_sel_type sel;
      logic         take;
      logic         load_vars;
      logic         round;
      logic [5:0]   round_idx;
      logic         add_hash;
      logic         finish;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [3:0] pos;
      logic       in_last;
      logic       in_full;
   } dp_stat_type;

   localparam word_type INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

// ===== rtl/sha256_if.sv =====
`timescale 1ns / 1ps

// Message word channel
interface sha256_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  byte_count;
   logic        last;

   modport source (output valid, output data_word, output byte_count, output last,
                   input ready);
   modport sink (input valid, input data_word, input byte_count, input last,
                 output ready);
endinterface

// Digest word channel
interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        final_word;

   modport source (output valid, output digest_word, output word_index,
                   output final_word, input ready);
   modport sink (input valid, input digest_word, input word_index,
                 input final_word, output ready);
endinterface

// ===== rtl/sha256_hash.sv =====
`timescale 1ns / 1ps

// SHA-256 hash engine.
// req_chan carries the message as big-endian 32-bit words with a count of valid
// leading bytes (below 4 only on the last word) and a last flag. The engine pads
// the message itself. rsp_chan returns the eight digest words, H0 first, with
// their index and a flag on the eighth.
// Words are taken one per cycle; every 16th word starts a compression of 64
// rounds plus a feed-forward step, during which no word is taken. A single
// round unit performs the rounds. After the last word, padding words enter one
// per cycle (up to 18 words), with one or two compressions along the way; the
// first digest word appears in the cycle after the final feed-forward, and the
// rest follow one per cycle while the receiver is ready.
// The digest sits in its own output buffer, so the next message is taken while
// a stalled receiver holds the last digest; only the final feed-forward of that
// next message waits until the buffer has drained.
// Synchronous reset returns the hash words to their initial values, clears the
// length and word position, and drops any pending digest.
module sha256_hash (
   input  logic         clock,
   input  logic         reset,
   sha256_req_if.sink   req_chan,
   sha256_rsp_if.source rsp_chan
);
   import sha256_pkg::*;

   cmd_type     cmd;
   dp_stat_type stat;
   digest_type  digest;
   logic        dig_busy;

   sha256_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .dig_busy  (dig_busy),
      .cmd       (cmd)
   );

   sha256_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .data_word  (req_chan.data_word),
      .byte_count (req_chan.byte_count),
      .last       (req_chan.last),
      .cmd        (cmd),
      .stat       (stat),
      .digest     (digest)
   );

   sha256_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (cmd.finish),
      .digest   (digest),
      .busy     (dig_busy),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/sha256_ctrl.sv =====
`timescale 1ns / 1ps

`include "sha256_hash_assert.svh"

module sha256_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sha256_pkg::dp_stat_type stat,
   input  logic                    dig_busy,
   output sha256_pkg::cmd_type     cmd
);
   import sha256_pkg::*;

   state_type  state_ff, state_in;
   logic [5:0] round_ff, round_in;
   logic       pad_ff, pad_in;        // message end seen, padding in progress
   logic       marker_ff, marker_in;  // 0x80 word still owed
   logic       hi_ff, hi_in;          // upper length word pushed
   logic       done_ff, done_in;      // lower length word pushed
   push_sel_type pad_sel;

   // Padding word choice
   always_comb begin
      priority if (marker_ff) begin
         pad_sel = PUSH_MARKER;
      end else if (stat.pos == 4'd14) begin
         pad_sel = PUSH_LEN_HI;
      end else if (stat.pos == 4'd15 && hi_ff) begin
         pad_sel = PUSH_LEN_LO;
      end else begin
         pad_sel = PUSH_ZERO;
      end
   end

   // Next state
   always_comb begin
      state_in  = state_ff;
      round_in  = round_ff;
      pad_in    = pad_ff;
      marker_in = marker_ff;
      hi_in     = hi_ff;
      done_in   = done_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pad_in    = stat.in_last;
               marker_in = stat.in_last && stat.in_full;
               hi_in     = 1'b0;
               done_in   = 1'b0;
               if (stat.pos == 4'd15) begin
                  state_in = ST_ROUND;
               end else if (stat.in_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (pad_sel == PUSH_MARKER) marker_in = 1'b0;
            if (pad_sel == PUSH_LEN_HI) hi_in = 1'b1;
            if (pad_sel == PUSH_LEN_LO) done_in = 1'b1;
            if (stat.pos == 4'd15) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) state_in = ST_ADD;
         end
         ST_ADD: begin
            if (done_ff) begin
               if (!dig_busy) begin
                  state_in = ST_IDLE;
                  pad_in   = 1'b0;
                  done_in  = 1'b0;
                  hi_in    = 1'b0;
               end
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.sel       = PUSH_ZERO;
      cmd.round_idx = round_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.push      = 1'b1;
               cmd.take      = 1'b1;
               cmd.sel       = stat.in_full ? PUSH_DATA : PUSH_TAIL;
               cmd.load_vars = (stat.pos == 4'd15);
            end
         end
         ST_PAD: begin
            cmd.push      = 1'b1;
            cmd.sel       = pad_sel;
            cmd.load_vars = (stat.pos == 4'd15);
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
         end
         ST_ADD: begin
            cmd.finish   = done_ff && !dig_busy;
            cmd.add_hash = !done_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         round_ff  <= '0;
         pad_ff    <= 1'b0;
         marker_ff <= 1'b0;
         hi_ff     <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         round_ff  <= round_in;
         pad_ff    <= pad_in;
         marker_ff <= marker_in;
         hi_ff     <= hi_in;
         done_ff   <= done_in;
      end
   end

   `ASSERT_IMPLY(a_finish_free, clock, reset, cmd.finish, !dig_busy, "finish into busy buffer")
   `ASSERT_IMPLY(a_load_on_full, clock, reset, cmd.load_vars,
                 cmd.push && stat.pos == 4'd15, "compression started on partial block")
   `ASSERT_NEXT(a_round_end, clock, reset, state_ff == ST_ROUND && round_ff == 6'd63,
                state_ff == ST_ADD && round_ff == 6'd0, "round count out of step")

endmodule

// ===== rtl/sha256_dp.sv =====
`timescale 1ns / 1ps

module sha256_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [31:0]             data_word,
   input  logic [2:0]              byte_count,
   input  logic                    last,
   input  sha256_pkg::cmd_type     cmd,
   output sha256_pkg::dp_stat_type stat,
   output sha256_pkg::digest_type  digest
);
   import sha256_pkg::*;

   word_type   hash_ff [8];
   word_type   vars_ff [8];
   word_type   sched_ff [16];
   logic [3:0] pos_ff;
   logic [63:0] len_ff;

   logic [2:0] eff_count;
   word_type   tail_word;
   word_type   push_word;
   word_type   next_w;
   word_type   t1, t2, big0, big1, ch, maj, s0, s1;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Byte count is a full word unless this is a short last word
   assign eff_count = (!last || byte_count > 3'd4) ? 3'd4 : byte_count;

   assign stat.pos     = pos_ff;
   assign stat.in_last = last;
   assign stat.in_full = (eff_count == 3'd4);

   // Short last word: keep valid bytes, append the 0x80 byte
   always_comb begin
      unique case (eff_count[1:0])
         2'd0:    tail_word = 32'h8000_0000;
         2'd1:    tail_word = {data_word[31:24], 24'h80_0000};
         2'd2:    tail_word = {data_word[31:16], 16'h8000};
         default: tail_word = {data_word[31:8], 8'h80};
      endcase
   end

   always_comb begin
      unique case (cmd.sel)
         PUSH_DATA:   push_word = data_word;
         PUSH_TAIL:   push_word = tail_word;
         PUSH_MARKER: push_word = 32'h8000_0000;
         PUSH_LEN_HI: push_word = len_ff[63:32];
         PUSH_LEN_LO: push_word = len_ff[31:0];
         default:     push_word = '0;
      endcase
   end

   // Message schedule: window holds W[t..t+15]
   assign s0     = rotr(sched_ff[1], 7) ^ rotr(sched_ff[1], 18) ^ (sched_ff[1] >> 3);
   assign s1     = rotr(sched_ff[14], 17) ^ rotr(sched_ff[14], 19) ^ (sched_ff[14] >> 10);
   assign next_w = s1 + sched_ff[9] + s0 + sched_ff[0];

   // One compression round
   assign big1 = rotr(vars_ff[4], 6) ^ rotr(vars_ff[4], 11) ^ rotr(vars_ff[4], 25);
   assign ch   = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign t1   = vars_ff[7] + big1 + ch + ROUND_K[cmd.round_idx] + sched_ff[0];
   assign big0 = rotr(vars_ff[0], 2) ^ rotr(vars_ff[0], 13) ^ rotr(vars_ff[0], 22);
   assign maj  = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
               ^ (vars_ff[1] & vars_ff[2]);
   assign t2   = big0 + maj;

   // Feed-forward sum, also the digest on the final block
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         digest[i] = hash_ff[i] + vars_ff[i];
      end
   end

   // Schedule window
   always_ff @(posedge clock) begin
      if (cmd.push || cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i + 1];
         end
         sched_ff[15] <= cmd.push ? push_word : next_w;
      end
   end

   // Working variables
   always_ff @(posedge clock) begin
      if (cmd.load_vars) begin
         for (int i = 0; i < 8; i++) begin
            vars_ff[i] <= hash_ff[i];
         end
      end else if (cmd.round) begin
         vars_ff[7] <= vars_ff[6];
         vars_ff[6] <= vars_ff[5];
         vars_ff[5] <= vars_ff[4];
         vars_ff[4] <= vars_ff[3] + t1;
         vars_ff[3] <= vars_ff[2];
         vars_ff[2] <= vars_ff[1];
         vars_ff[1] <= vars_ff[0];
         vars_ff[0] <= t1 + t2;
      end
   end

   // Hash words, word position and bit length
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= INIT_H[i];
         end
         pos_ff <= '0;
         len_ff <= '0;
      end else begin
         if (cmd.push) pos_ff <= pos_ff + 4'd1;
         if (cmd.take) len_ff <= len_ff + {58'd0, eff_count, 3'd0};
         if (cmd.finish) begin
            for (int i = 0; i < 8; i++) begin
               hash_ff[i] <= INIT_H[i];
            end
            len_ff <= '0;
         end else if (cmd.add_hash) begin
            for (int i = 0; i < 8; i++) begin
               hash_ff[i] <= digest[i];
            end
         end
      end
   end

endmodule

// ===== rtl/sha256_out.sv =====
`timescale 1ns / 1ps

`include "sha256_hash_assert.svh"

module sha256_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  sha256_pkg::digest_type digest,
   output logic                   busy,
   sha256_rsp_if.source           rsp_chan
);
   import sha256_pkg::*;

   word_type   dig_ff [8];
   logic [2:0] cnt_ff;
   logic       busy_ff;
   logic       take;

   assign take = busy_ff && rsp_chan.ready;
   assign busy = busy_ff;

   assign rsp_chan.valid       = busy_ff;
   assign rsp_chan.digest_word = dig_ff[0];
   assign rsp_chan.word_index  = cnt_ff;
   assign rsp_chan.final_word  = (cnt_ff == 3'd7);

   // Digest words shift toward the output one item at a time
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 8; i++) begin
            dig_ff[i] <= digest[i];
         end
      end else if (take) begin
         for (int i = 0; i < 7; i++) begin
            dig_ff[i] <= dig_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (take) begin
         cnt_ff <= cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) busy_ff <= 1'b0;
      end
   end

   `ASSERT_IMPLY(a_load_idle, clock, reset, load, !busy_ff, "digest overwritten")
   `ASSERT_NEXT(a_last_drains, clock, reset, take && cnt_ff == 3'd7, !busy_ff,
                "buffer still busy after last item")

endmodule
